// ----- rtl/ipv4fl_pkg.sv -----
`timescale 1ns / 1ps
package ipv4fl_pkg;

	// header sum of up to thirty 16-bit words
	localparam int SUM_W            = 21;
	localparam int MIN_HEADER_WORDS = 10;
	localparam int WORD_TTL         = 4;
	localparam int WORD_CSUM        = 5;
	localparam int WORD_DST_HI      = 8;
	localparam int WORD_DST_LO      = 9;
	localparam int QUEUE_DEPTH      = 4;

	typedef enum logic [1:0] {
		OP_HEADER   = 2'd0,
		OP_ROUTE_WR = 2'd1,
		OP_NBR_WR   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_FORWARD     = 2'd0,
		ST_NO_ROUTE    = 2'd1,
		ST_NO_NEIGHBOR = 2'd2,
		ST_SHORT       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_ROUTE_WR,
		CMD_NBR_WR,
		CMD_LOOKUP,
		CMD_SHORT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [3:0]        idx;
		logic [31:0]       addr;
		logic [31:0]       mask;
		logic [1:0]        port;
		logic [47:0]       mac;
		logic              ok;
		logic [7:0]        ttl;
		logic [SUM_W-1:0]  sum;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_push_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROUTE,
		B_NEIGHBOR
	} back_state_t;

endpackage

// ----- rtl/ipv4fl_if.sv -----
`timescale 1ns / 1ps
interface ipv4fl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  entry_index;
	logic [31:0] entry_addr;
	logic [31:0] entry_mask;
	logic [1:0]  entry_port;
	logic [47:0] entry_mac;
	logic        entry_valid;
	logic [15:0] header_word;
	logic        header_last;

	modport source (
		output valid, opcode, entry_index, entry_addr, entry_mask, entry_port,
		output entry_mac, entry_valid, header_word, header_last,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_index, entry_addr, entry_mask, entry_port,
		input  entry_mac, entry_valid, header_word, header_last,
		output ready
	);
endinterface

interface ipv4fl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  out_port;
	logic [47:0] next_hop_mac;
	logic [7:0]  new_ttl;
	logic [15:0] new_checksum;
	logic [31:0] dest_addr;

	modport source (
		output valid, status, out_port, next_hop_mac, new_ttl, new_checksum, dest_addr,
		input  ready
	);
	modport sink (
		input  valid, status, out_port, next_hop_mac, new_ttl, new_checksum, dest_addr,
		output ready
	);
endinterface

// ----- rtl/ipv4_forward_lookup.sv -----
`timescale 1ns / 1ps
// ipv4 forwarding lookup
// req channel: one request per handshake; opcode selects a header word, a
// route table write or a neighbour table write. header words stream in network
// order, header_last marks the final one. table writes to slots past the table
// size and the unused opcode are dropped without a result.
// rsp channel: one result per header: status, port, next-hop mac, decremented
// ttl, recomputed checksum and destination.
// the front takes one request per cycle while the four-entry command queue has
// room; table writes travel through the same queue, so each lookup sees
// exactly the writes made before its header.
// the back pops one command at a time; table writes and short headers are
// handled in the idle state. a lookup scans the route table one entry per
// cycle through its ram read port and then, once a route is found, the
// neighbour table the same way. one lookup is in flight at a time. while rsp
// is stalled the result holds in its register and the front keeps accepting
// words until the queue fills.
// reset clears all routes and neighbour valid marks and the header state.
module ipv4_forward_lookup
	import ipv4fl_pkg::*;
#(
	parameter int ROUTE_ENTRIES    = 16,
	parameter int NEIGHBOR_ENTRIES = 16,
	parameter int MAX_HEADER_WORDS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	ipv4fl_req_if.sink   req,
	ipv4fl_rsp_if.source rsp
);

	q_push_t q_push;
	logic    q_full;
	logic    q_pop;
	logic    q_vld;
	cmd_t    q_head;

	ipv4fl_front #(
		.ROUTE_ENTRIES    (ROUTE_ENTRIES),
		.NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES),
		.MAX_HEADER_WORDS (MAX_HEADER_WORDS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push)
	);

	ipv4fl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.vld    (q_vld),
		.head   (q_head)
	);

	ipv4fl_back #(
		.ROUTE_ENTRIES    (ROUTE_ENTRIES),
		.NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_head (q_head),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/ipv4fl_ram.sv -----
`timescale 1ns / 1ps
module ipv4fl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/ipv4fl_queue.sv -----
`timescale 1ns / 1ps
module ipv4fl_queue
	import ipv4fl_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t q_push,
	output logic    full,
	input  logic    pop,
	output logic    vld,
	output cmd_t    head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign vld     = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = q_push.push && !full;
	assign do_pop  = pop && vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_push.cmd;
		end
	end

`ifndef SYNTHESIS
	// the front holds off when the queue is full, so no command is ever pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.push |-> !full)
		else $error("push into full queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(DEPTH))
		else $error("queue count overflow");
`endif

endmodule

// ----- rtl/ipv4fl_front.sv -----
`timescale 1ns / 1ps
module ipv4fl_front
	import ipv4fl_pkg::*;
#(
	parameter int ROUTE_ENTRIES    = 16,
	parameter int NEIGHBOR_ENTRIES = 16,
	parameter int MAX_HEADER_WORDS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	ipv4fl_req_if.sink   req,
	input  logic         q_full,
	output q_push_t      q_push
);

	localparam int CW = $clog2(MAX_HEADER_WORDS + 1);

	logic [CW-1:0]    cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0]      dest_q;
	logic [7:0]       ttl_q;

	logic             accept;
	logic             hdr_take;
	logic             in_rng;
	logic [15:0]      sum_add;
	logic [CW-1:0]    cnt_nx;
	logic [SUM_W-1:0] sum_nx;
	logic [31:0]      dest_nx;
	logic [7:0]       ttl_nx;
	logic             route_idx_ok;
	logic             nbr_idx_ok;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign hdr_take  = accept && (req.opcode == OP_HEADER);

	assign route_idx_ok = (9'(req.entry_index) < 9'(ROUTE_ENTRIES));
	assign nbr_idx_ok   = (9'(req.entry_index) < 9'(NEIGHBOR_ENTRIES));

	// running header state with this word folded in
	always_comb begin
		in_rng  = (cnt_q < CW'(MAX_HEADER_WORDS));
		cnt_nx  = cnt_q;
		sum_nx  = sum_q;
		dest_nx = dest_q;
		ttl_nx  = ttl_q;
		if (cnt_q == CW'(WORD_TTL)) begin
			sum_add = {req.header_word[15:8] - 8'd1, req.header_word[7:0]};
		end else if (cnt_q == CW'(WORD_CSUM)) begin
			sum_add = '0;
		end else begin
			sum_add = req.header_word;
		end
		if (in_rng) begin
			cnt_nx = cnt_q + 1'b1;
			sum_nx = sum_q + SUM_W'(sum_add);
			if (cnt_q == CW'(WORD_TTL)) begin
				ttl_nx = req.header_word[15:8];
			end
			if (cnt_q == CW'(WORD_DST_HI)) begin
				dest_nx[31:16] = req.header_word;
			end else if (cnt_q == CW'(WORD_DST_LO)) begin
				dest_nx[15:0] = req.header_word;
			end
		end
	end

	always_comb begin
		q_push          = '0;
		q_push.cmd.idx  = req.entry_index;
		q_push.cmd.addr = req.entry_addr;
		q_push.cmd.mask = req.entry_mask;
		q_push.cmd.port = req.entry_port;
		q_push.cmd.mac  = req.entry_mac;
		q_push.cmd.ok   = req.entry_valid;
		q_push.cmd.kind = CMD_LOOKUP;
		unique case (req.opcode)
			OP_HEADER: begin
				q_push.push = accept && req.header_last;
				if (cnt_nx < CW'(MIN_HEADER_WORDS)) begin
					q_push.cmd.kind = CMD_SHORT;
				end
				q_push.cmd.addr = dest_nx;
				q_push.cmd.ttl  = ttl_nx - 8'd1;
				q_push.cmd.sum  = sum_nx;
			end
			OP_ROUTE_WR: begin
				q_push.push     = accept && route_idx_ok;
				q_push.cmd.kind = CMD_ROUTE_WR;
			end
			OP_NBR_WR: begin
				q_push.push     = accept && nbr_idx_ok;
				q_push.cmd.kind = CMD_NBR_WR;
			end
			default: begin
				q_push.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			dest_q <= '0;
			ttl_q  <= '0;
		end else if (hdr_take) begin
			if (req.header_last) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				dest_q <= '0;
				ttl_q  <= '0;
			end else begin
				cnt_q  <= cnt_nx;
				sum_q  <= sum_nx;
				dest_q <= dest_nx;
				ttl_q  <= ttl_nx;
			end
		end
	end

`ifndef SYNTHESIS
	a_hdr_restart: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_take && req.header_last |=> (cnt_q == '0) && (sum_q == '0))
		else $error("header state not cleared after last word");
`endif

endmodule

// ----- rtl/ipv4fl_back.sv -----
`timescale 1ns / 1ps
module ipv4fl_back
	import ipv4fl_pkg::*;
#(
	parameter int ROUTE_ENTRIES    = 16,
	parameter int NEIGHBOR_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_vld,
	input  cmd_t          q_head,
	output logic          q_pop,
	ipv4fl_rsp_if.source  rsp
);

	localparam int RIW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int NIW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
	localparam int SW  = (RIW > NIW) ? RIW : NIW;

	function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] s);
		logic [16:0] s1;
		logic [15:0] s2;
		s1 = 17'(s[SUM_W-1:16]) + 17'(s[15:0]);
		s2 = s1[15:0] + 16'(s1[16]);
		return ~s2;
	endfunction

	back_state_t      state_q;
	back_state_t      state_nx;

	logic [1:0]       route_port_q [ROUTE_ENTRIES];
	logic             nbr_ok_q     [NEIGHBOR_ENTRIES];

	logic [SW-1:0]    scan_q;
	logic             scan_done_q;
	logic             rd_vld_s1;
	logic [SW-1:0]    rd_idx_s1;

	logic [31:0]      job_dest_q;
	logic [7:0]       job_ttl_q;
	logic [SUM_W-1:0] job_sum_q;
	logic [1:0]       job_port_q;

	logic             out_vld_q;
	status_t          res_status_q;
	logic [1:0]       res_port_q;
	logic [47:0]      res_mac_q;
	logic [7:0]       res_ttl_q;
	logic [15:0]      res_csum_q;
	logic [31:0]      res_dest_q;

	logic             route_we;
	logic             nbr_we;
	logic             start;
	logic             short_done;
	logic             issue;
	logic [SW-1:0]    scan_limit;
	logic             route_hit;
	logic             route_end;
	logic             nbr_hit;
	logic             nbr_end;
	logic             route_miss;
	logic             nbr_miss;
	logic             restart;
	logic             finish;

	logic [63:0]      route_rd;
	logic [79:0]      nbr_rd;

	ipv4fl_ram #(.WIDTH(64), .DEPTH(ROUTE_ENTRIES)) u_route_ram (
		.clk   (clk),
		.we    (route_we),
		.waddr (RIW'(q_head.idx)),
		.wdata ({q_head.addr, q_head.mask}),
		.re    (issue && (state_q == B_ROUTE)),
		.raddr (scan_q[RIW-1:0]),
		.rdata (route_rd)
	);

	ipv4fl_ram #(.WIDTH(80), .DEPTH(NEIGHBOR_ENTRIES)) u_nbr_ram (
		.clk   (clk),
		.we    (nbr_we),
		.waddr (NIW'(q_head.idx)),
		.wdata ({q_head.addr, q_head.mac}),
		.re    (issue && (state_q == B_NEIGHBOR)),
		.raddr (scan_q[NIW-1:0]),
		.rdata (nbr_rd)
	);

	// outputs of the sequencer
	always_comb begin
		q_pop      = 1'b0;
		route_we   = 1'b0;
		nbr_we     = 1'b0;
		start      = 1'b0;
		short_done = 1'b0;
		issue      = 1'b0;
		scan_limit = '0;
		route_hit  = 1'b0;
		route_end  = 1'b0;
		nbr_hit    = 1'b0;
		nbr_end    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_vld) begin
					unique case (q_head.kind)
						CMD_ROUTE_WR: begin
							q_pop    = 1'b1;
							route_we = 1'b1;
						end
						CMD_NBR_WR: begin
							q_pop  = 1'b1;
							nbr_we = 1'b1;
						end
						CMD_LOOKUP: begin
							q_pop = !out_vld_q;
							start = !out_vld_q;
						end
						CMD_SHORT: begin
							q_pop      = !out_vld_q;
							short_done = !out_vld_q;
						end
					endcase
				end
			end
			B_ROUTE: begin
				scan_limit = SW'(ROUTE_ENTRIES - 1);
				issue      = !scan_done_q;
				route_hit  = rd_vld_s1 && (route_port_q[rd_idx_s1[RIW-1:0]] != 2'd0)
					&& ((job_dest_q & route_rd[31:0]) == route_rd[63:32]);
				route_end  = rd_vld_s1 && (rd_idx_s1 == scan_limit);
			end
			B_NEIGHBOR: begin
				scan_limit = SW'(NEIGHBOR_ENTRIES - 1);
				issue      = !scan_done_q;
				nbr_hit    = rd_vld_s1 && nbr_ok_q[rd_idx_s1[NIW-1:0]]
					&& (nbr_rd[79:48] == job_dest_q);
				nbr_end    = rd_vld_s1 && (rd_idx_s1 == scan_limit);
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign route_miss = route_end && !route_hit;
	assign nbr_miss   = nbr_end && !nbr_hit;
	assign restart    = start || route_hit;
	assign finish     = short_done || route_miss || nbr_hit || nbr_miss;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (start) begin
					state_nx = B_ROUTE;
				end
			end
			B_ROUTE: begin
				if (route_hit) begin
					state_nx = B_NEIGHBOR;
				end else if (route_end) begin
					state_nx = B_IDLE;
				end
			end
			B_NEIGHBOR: begin
				if (nbr_hit || nbr_end) begin
					state_nx = B_IDLE;
				end
			end
			default: begin
				state_nx = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			scan_q      <= '0;
			scan_done_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < ROUTE_ENTRIES; i++) begin
				route_port_q[i] <= 2'd0;
			end
			for (int i = 0; i < NEIGHBOR_ENTRIES; i++) begin
				nbr_ok_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_nx;
			// one table entry read per cycle, compared in the cycle after its read
			if (restart) begin
				scan_q      <= '0;
				scan_done_q <= 1'b0;
				rd_vld_s1   <= 1'b0;
			end else if (issue) begin
				rd_vld_s1 <= 1'b1;
				if (scan_q == scan_limit) begin
					scan_done_q <= 1'b1;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			if (route_we) begin
				route_port_q[RIW'(q_head.idx)] <= q_head.port;
			end
			if (nbr_we) begin
				nbr_ok_q[NIW'(q_head.idx)] <= q_head.ok;
			end
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= scan_q;
		end
		if (start) begin
			job_dest_q <= q_head.addr;
			job_ttl_q  <= q_head.ttl;
			job_sum_q  <= q_head.sum;
		end
		if (route_hit) begin
			job_port_q <= route_port_q[rd_idx_s1[RIW-1:0]];
		end
		if (short_done) begin
			res_status_q <= ST_SHORT;
			res_port_q   <= '0;
			res_mac_q    <= '0;
			res_ttl_q    <= '0;
			res_csum_q   <= '0;
			res_dest_q   <= '0;
		end else if (route_miss || nbr_hit || nbr_miss) begin
			res_ttl_q  <= job_ttl_q;
			res_csum_q <= fold_sum(job_sum_q);
			res_dest_q <= job_dest_q;
			if (route_miss) begin
				res_status_q <= ST_NO_ROUTE;
				res_port_q   <= '0;
				res_mac_q    <= '0;
			end else if (nbr_hit) begin
				res_status_q <= ST_FORWARD;
				res_port_q   <= job_port_q;
				res_mac_q    <= nbr_rd[47:0];
			end else begin
				res_status_q <= ST_NO_NEIGHBOR;
				res_port_q   <= job_port_q;
				res_mac_q    <= '0;
			end
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.status       = res_status_q;
	assign rsp.out_port     = res_port_q;
	assign rsp.next_hop_mac = res_mac_q;
	assign rsp.new_ttl      = res_ttl_q;
	assign rsp.new_checksum = res_csum_q;
	assign rsp.dest_addr    = res_dest_q;

`ifndef SYNTHESIS
	// a result is only produced into an empty output register
	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !out_vld_q)
		else $error("result overwrites pending output");
	// table writes never land while a lookup is reading the tables
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> !q_pop)
		else $error("queue popped during lookup");
	a_nbr_has_route: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_hit |-> (job_port_q != 2'd0))
		else $error("neighbour hit without route");
`endif

endmodule
